// ----- rtl/csvfs_pkg.sv -----
// csvfs_pkg: shared types and constants for the CSV field splitter.
// Used by csvfs_front, csvfs_queue, csvfs_back and csv_field_splitter.
// No dependencies.
package csvfs_pkg;

    localparam int BYTE_W  = 8;
    localparam int COL_W   = 6;   // result column width
    localparam int POS_W   = 7;   // field position / column count width
    localparam int ROW_W   = 32;
    localparam int IDX_W   = 3;   // configuration register index width
    localparam int COL_CAP = 64;  // columns that the result column field can address

    localparam int QUEUE_DEPTH = 4;  // power of two

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DELIMITER  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_QUOTE      = 3'd1;
    localparam logic [IDX_W-1:0] CFG_QUOTE_EN   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ESCAPE     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_ESCAPE_EN  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_COLUMNS    = 3'd5;

    // Reset values
    localparam logic [BYTE_W-1:0] RST_DELIMITER = 8'd44;
    localparam logic [BYTE_W-1:0] RST_QUOTE     = 8'd34;
    localparam logic              RST_QUOTE_EN  = 1'b1;
    localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd92;
    localparam logic              RST_ESCAPE_EN = 1'b0;
    localparam logic [POS_W-1:0]  RST_COLUMNS   = 7'd1;

    // Result kind codes
    localparam logic KIND_DATA      = 1'b0;
    localparam logic KIND_FIELD_END = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] delimiter_code;
        logic [BYTE_W-1:0] quote_code;
        logic              quote_enable;
        logic [BYTE_W-1:0] escape_code;
        logic              escape_enable;
        logic [POS_W-1:0]  column_count;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_FIELD_END,
        CMD_ROW_END
    } cmd_kind_t;

    // One queued command: a single result, or a run of field ends that
    // closes a row from start_col up to end_col.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data_byte;
        logic [COL_W-1:0]  start_col;
        logic [COL_W-1:0]  end_col;
        logic [ROW_W-1:0]  row_number;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- rtl/csvfs_front.sv -----
// csvfs_front: accepts line bytes, tracks escape/quote/column state and
// turns each byte or end of line into at most one queued command.
// Depends on csvfs_pkg.
module csvfs_front #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [csvfs_pkg::BYTE_W-1:0] s_tdata,   // [7:0] char_code
    input  logic [0:0]                   s_tuser,   // [0] line_end
    input  csvfs_pkg::cfg_t              cfg,
    input  csvfs_pkg::q_status_t         q_status,
    output logic                         push,
    output csvfs_pkg::cmd_t              push_cmd
);
    import csvfs_pkg::*;

    localparam int COL_LIMIT = (MAX_COLUMNS < COL_CAP) ? MAX_COLUMNS : COL_CAP;

    logic             escape_pending_reg, escape_pending_next;
    logic             inside_quotes_reg, inside_quotes_next;
    logic             line_started_reg, line_started_next;
    logic [POS_W-1:0] field_position_reg, field_position_next;
    logic [ROW_W-1:0] rows_done_reg, rows_done_next;

    logic             accept;
    logic [POS_W-1:0] ncols;
    logic [POS_W-1:0] last_col;
    logic [POS_W-1:0] start_pos;
    logic             emit_data;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        // zero acts as one, then clamp to the supported column limit
        ncols = (cfg.column_count == '0) ? POS_W'(1) : cfg.column_count;
        if (ncols > POS_W'(COL_LIMIT)) begin
            ncols = POS_W'(COL_LIMIT);
        end
        last_col  = ncols - POS_W'(1);
        start_pos = (field_position_reg > last_col) ? last_col : field_position_reg;
    end

    always_comb begin
        escape_pending_next = escape_pending_reg;
        inside_quotes_next  = inside_quotes_reg;
        line_started_next   = line_started_reg;
        field_position_next = field_position_reg;
        rows_done_next      = rows_done_reg;
        push                = 1'b0;
        emit_data           = 1'b0;
        push_cmd.kind       = CMD_DATA;
        push_cmd.data_byte  = s_tdata;
        push_cmd.start_col  = field_position_reg[COL_W-1:0];
        push_cmd.end_col    = last_col[COL_W-1:0];
        push_cmd.row_number = rows_done_reg;

        if (accept) begin
            if (s_tuser[0]) begin
                if (line_started_reg) begin
                    push                = 1'b1;
                    push_cmd.kind       = CMD_ROW_END;
                    push_cmd.start_col  = start_pos[COL_W-1:0];
                    rows_done_next      = rows_done_reg + ROW_W'(1);
                    escape_pending_next = 1'b0;
                    inside_quotes_next  = 1'b0;
                    line_started_next   = 1'b0;
                    field_position_next = '0;
                end
            end else begin
                line_started_next = 1'b1;
                if (escape_pending_reg) begin
                    escape_pending_next = 1'b0;
                    emit_data           = 1'b1;
                end else if (cfg.escape_enable && s_tdata == cfg.escape_code) begin
                    escape_pending_next = 1'b1;
                end else if (cfg.quote_enable && s_tdata == cfg.quote_code) begin
                    inside_quotes_next = !inside_quotes_reg;
                end else if (!inside_quotes_reg && s_tdata == cfg.delimiter_code) begin
                    if (field_position_reg < ncols) begin
                        // the last column is closed only at end of line
                        if ((field_position_reg + POS_W'(1)) < ncols) begin
                            push          = 1'b1;
                            push_cmd.kind = CMD_FIELD_END;
                        end
                        field_position_next = field_position_reg + POS_W'(1);
                    end
                end else begin
                    emit_data = 1'b1;
                end

                if (emit_data && field_position_reg < ncols) begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_DATA;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_pending_reg <= 1'b0;
            inside_quotes_reg  <= 1'b0;
            line_started_reg   <= 1'b0;
            field_position_reg <= '0;
            rows_done_reg      <= '0;
        end else begin
            escape_pending_reg <= escape_pending_next;
            inside_quotes_reg  <= inside_quotes_next;
            line_started_reg   <= line_started_next;
            field_position_reg <= field_position_next;
            rows_done_reg      <= rows_done_next;
        end
    end

endmodule

// ----- rtl/csvfs_queue.sv -----
// csvfs_queue: small command FIFO between the front and back parts.
// Depends on csvfs_pkg (cmd_t, q_status_t, QUEUE_DEPTH).
module csvfs_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  csvfs_pkg::cmd_t      push_cmd,
    input  logic                 pop,
    output csvfs_pkg::cmd_t      head_cmd,
    output csvfs_pkg::q_status_t q_status
);
    import csvfs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_cmd       = entry_reg[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/csvfs_back.sv -----
// csvfs_back: drains queued commands into the result stream, expanding a
// row end into one field end per remaining column. Registered output.
// Depends on csvfs_pkg.
module csvfs_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  csvfs_pkg::cmd_t      head_cmd,
    input  csvfs_pkg::q_status_t q_status,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] data_byte, [13:8] column, [45:14] row_number, [47:46] zero
    output logic [47:0]          m_tdata,
    output logic [0:0]           m_tuser,  // [0] kind
    output logic                 m_tlast   // row_last
);
    import csvfs_pkg::*;

    logic              valid_reg, valid_next;
    logic              kind_reg, kind_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              last_reg, last_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    // padding run in progress
    logic              iter_active_reg, iter_active_next;
    logic [COL_W-1:0]  iter_col_reg, iter_col_next;
    logic [COL_W-1:0]  iter_end_reg, iter_end_next;
    logic [ROW_W-1:0]  iter_row_reg, iter_row_next;

    logic out_free;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next       = valid_reg;
        kind_next        = kind_reg;
        byte_next        = byte_reg;
        col_next         = col_reg;
        last_next        = last_reg;
        row_next         = row_reg;
        iter_active_next = iter_active_reg;
        iter_col_next    = iter_col_reg;
        iter_end_next    = iter_end_reg;
        iter_row_next    = iter_row_reg;
        pop              = 1'b0;

        if (out_free) begin
            if (iter_active_reg) begin
                valid_next       = 1'b1;
                kind_next        = KIND_FIELD_END;
                byte_next        = '0;
                col_next         = iter_col_reg;
                last_next        = (iter_col_reg == iter_end_reg);
                row_next         = iter_row_reg;
                iter_active_next = (iter_col_reg != iter_end_reg);
                iter_col_next    = iter_col_reg + COL_W'(1);
            end else if (!q_status.empty) begin
                pop        = 1'b1;
                valid_next = 1'b1;
                col_next   = head_cmd.start_col;
                row_next   = head_cmd.row_number;
                last_next  = 1'b0;
                unique case (head_cmd.kind)
                    CMD_DATA: begin
                        kind_next = KIND_DATA;
                        byte_next = head_cmd.data_byte;
                    end
                    CMD_FIELD_END: begin
                        kind_next = KIND_FIELD_END;
                        byte_next = '0;
                    end
                    CMD_ROW_END: begin
                        kind_next = KIND_FIELD_END;
                        byte_next = '0;
                        last_next = (head_cmd.start_col == head_cmd.end_col);
                        iter_active_next = (head_cmd.start_col != head_cmd.end_col);
                        iter_col_next    = head_cmd.start_col + COL_W'(1);
                        iter_end_next    = head_cmd.end_col;
                        iter_row_next    = head_cmd.row_number;
                    end
                    default: begin
                        pop        = 1'b0;
                        valid_next = 1'b0;
                    end
                endcase
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            iter_active_reg <= 1'b0;
        end else begin
            valid_reg       <= valid_next;
            iter_active_reg <= iter_active_next;
        end
        kind_reg     <= kind_next;
        byte_reg     <= byte_next;
        col_reg      <= col_next;
        last_reg     <= last_next;
        row_reg      <= row_next;
        iter_col_reg <= iter_col_next;
        iter_end_reg <= iter_end_next;
        iter_row_reg <= iter_row_next;
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = {2'b00, row_reg, col_reg, byte_reg};
    assign m_tuser[0] = kind_reg;
    assign m_tlast    = last_reg;

endmodule

// ----- rtl/csv_field_splitter.sv -----
// csv_field_splitter: top level of the CSV field splitter.
// Depends on csvfs_pkg, csvfs_front, csvfs_queue and csvfs_back.
//
// Splits a byte stream into CSV fields. Each input transaction is one line
// byte (s_tuser[0] = 0) or an end-of-line marker (s_tuser[0] = 1). The
// front part classifies one item per cycle while the queue is not full and
// posts at most one command into a 4-entry queue; the back part emits one
// result per cycle from a registered output while m_tready is high. Bytes are
// taken at one per cycle while the queue is not full. An end of line that
// closes a row at column p of n columns yields n - min(p, n - 1) result
// transactions, one field end per column up to the last, and the input stalls
// once the queue fills behind it. Configuration writes are accepted every
// cycle and are meant to be issued only while the block is idle. There is no post-reset clearing pass.
module csv_field_splitter #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] char_code
    input  logic [0:0]                     s_tuser,   // [0] line_end
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] data_byte, [13:8] column, [45:14] row_number, [47:46] zero
    output logic [47:0]                    m_tdata,
    output logic [0:0]                     m_tuser,   // [0] kind
    output logic                           m_tlast,   // row_last
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [csvfs_pkg::IDX_W-1:0]    cfg_index,
    input  logic [7:0]                     cfg_data
);
    import csvfs_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    q_status_t q_status;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    logic      push;
    logic      pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DELIMITER: cfg_next.delimiter_code = cfg_data;
                CFG_QUOTE:     cfg_next.quote_code     = cfg_data;
                CFG_QUOTE_EN:  cfg_next.quote_enable   = cfg_data[0];
                CFG_ESCAPE:    cfg_next.escape_code    = cfg_data;
                CFG_ESCAPE_EN: cfg_next.escape_enable  = cfg_data[0];
                CFG_COLUMNS:   cfg_next.column_count   = cfg_data[POS_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delimiter_code <= RST_DELIMITER;
            cfg_reg.quote_code     <= RST_QUOTE;
            cfg_reg.quote_enable   <= RST_QUOTE_EN;
            cfg_reg.escape_code    <= RST_ESCAPE;
            cfg_reg.escape_enable  <= RST_ESCAPE_EN;
            cfg_reg.column_count   <= RST_COLUMNS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    csvfs_front #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    csvfs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    csvfs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // front never posts into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("command pushed into full queue");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("command popped from empty queue");

    // a row-closing result is always a field end with a zero data byte
    a_last_is_field_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser[0] == KIND_FIELD_END && m_tdata[7:0] == 8'd0))
        else $error("row_last on a data result");

endmodule

// ----- dv/tb_csv_field_splitter.sv -----
// tb_csv_field_splitter: self-checking testbench for csv_field_splitter. It runs directed
// rows and then random rows under several register settings, with random stalls on both streams.
// Depends on csvfs_pkg and the csv_field_splitter RTL.
module tb_csv_field_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    import csvfs_pkg::*;

    localparam int MAX_COLS      = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int GAP_PERCENT   = 35;
    localparam int PHASE_ITEMS   = 52;
    localparam int RANDOM_PHASES = 8;

    // indexes with no register behind them; writes must be ignored
    localparam logic [IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [COL_W-1:0]  col_num;
        logic              row_last;
        logic [ROW_W-1:0]  row_number;
    } field_result_t;

    // Tracks the splitter state and register settings, and queues the
    // results that each accepted item is due to produce.
    class field_tracker;
        logic [BYTE_W-1:0] delim;
        logic [BYTE_W-1:0] quote;
        logic [BYTE_W-1:0] esc;
        logic              quote_on;
        logic              esc_on;
        logic [POS_W-1:0]  columns;

        logic              escaped;
        logic              quoted;
        logic              started;
        logic [POS_W-1:0]  position;
        logic [ROW_W-1:0]  rows;

        field_result_t     expected_fields[$];
        int                errors;

        function new();
            delim    = RST_DELIMITER;
            quote    = RST_QUOTE;
            quote_on = RST_QUOTE_EN;
            esc      = RST_ESCAPE;
            esc_on   = RST_ESCAPE_EN;
            columns  = RST_COLUMNS;
            escaped  = 1'b0;
            quoted   = 1'b0;
            started  = 1'b0;
            position = '0;
            rows     = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_DELIMITER: delim    = val;
                CFG_QUOTE:     quote    = val;
                CFG_QUOTE_EN:  quote_on = val[0];
                CFG_ESCAPE:    esc      = val;
                CFG_ESCAPE_EN: esc_on   = val[0];
                CFG_COLUMNS:   columns  = val[POS_W-1:0];
                default: ;
            endcase
        endfunction

        function int active_columns();
            int n;
            n = columns;
            if (n < 1) n = 1;
            if (n > MAX_COLS) n = MAX_COLS;
            if (n > COL_CAP) n = COL_CAP;
            return n;
        endfunction

        function void push(logic kind, logic [7:0] b, int col, logic last);
            field_result_t r;
            r.kind         = kind;
            r.data_byte    = b;
            r.col_num      = col[COL_W-1:0];
            r.row_last     = last;
            r.row_number   = rows;
            expected_fields.insert(expected_fields.size(), r);
        endfunction

        function void take_item(logic [7:0] c, logic eol);
            int ncols;
            int col;
            ncols = active_columns();
            if (eol) begin
                if (!started) return;   // blank line: no output, row count holds
                col = position;
                if (col > ncols - 1) col = ncols - 1;
                while (col < ncols) begin
                    push(KIND_FIELD_END, 8'h00, col, col == ncols - 1);
                    col++;
                end
                rows     = rows + 1;
                escaped  = 1'b0;
                quoted   = 1'b0;
                started  = 1'b0;
                position = '0;
                return;
            end
            started = 1'b1;
            if (escaped) begin
                escaped = 1'b0;
            end else if (esc_on && c == esc) begin
                escaped = 1'b1;
                return;
            end else if (quote_on && c == quote) begin
                quoted = !quoted;
                return;
            end else if (!quoted && c == delim) begin
                // the last column is closed only at end of line
                if (position < ncols) begin
                    if (position + 1 < ncols) push(KIND_FIELD_END, 8'h00, position, 1'b0);
                    position++;
                end
                return;
            end
            if (position < ncols) push(KIND_DATA, c, position, 1'b0);
        endfunction

        function void compare(string what, longint unsigned want, longint unsigned seen);
            if (want != seen) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
            end
        endfunction

        function void check_field(field_result_t got, logic [1:0] pad);
            field_result_t want;
            if (expected_fields.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d byte %0d col %0d",
                         $time, got.kind, got.data_byte, got.col_num);
                return;
            end
            want = expected_fields.pop_front();
            compare("kind", want.kind, got.kind);
            compare("data_byte", want.data_byte, got.data_byte);
            compare("column", want.col_num, got.col_num);
            compare("row_last", want.row_last, got.row_last);
            compare("row_number", want.row_number, got.row_number);
            compare("tdata padding", 0, pad);
        endfunction

        function int waiting();
            return expected_fields.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [47:0]         m_tdata;
    logic [0:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [7:0]          cfg_data;

    field_tracker trk = new();
    bit           no_stall = 1'b0;
    int           items_sent = 0;

    csv_field_splitter #(
        .MAX_COLUMNS(MAX_COLS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit take_gap();
        return !no_stall && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    // result side: check each accepted transaction, then pick next tready
    always @(posedge aclk) begin
        field_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind         = m_tuser[0];
            got.data_byte    = m_tdata[7:0];
            got.col_num      = m_tdata[13:8];
            got.row_last     = m_tlast;
            got.row_number   = m_tdata[45:14];
            trk.check_field(got, m_tdata[47:46]);
        end
        m_tready <= !take_gap();
    end

    // tvalid stays high across back-to-back transactions; it only drops in a gap or in drain()
    task automatic send_item(input logic [7:0] c, input logic eol);
        while (take_gap()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eol;
        do @(posedge aclk); while (!s_tready);
        trk.take_item(c, eol);
        items_sent++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        trk.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every queued result is out and the pipeline has gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (trk.waiting() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 25) return trk.delim;
        if (r < 37) return trk.quote;
        if (r < 45) return trk.esc;
        return 8'($urandom);
    endfunction

    task automatic send_line();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(10);
        repeat (len) send_item(pick_char(), 1'b0);
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic load_settings(input int phase);
        logic [7:0] d, q, e, qen, een, cols;
        d   = 8'($urandom);
        q   = 8'($urandom);
        e   = 8'($urandom);
        qen = 8'($urandom);
        een = 8'($urandom);
        if ($urandom_range(4) == 0) q = d;
        if ($urandom_range(4) == 0) e = $urandom_range(1) ? q : d;
        case ($urandom_range(9))
            0:       cols = 8'd64;
            1:       cols = 8'($urandom_range(65, 127));
            2:       cols = 8'($urandom);
            default: cols = 8'($urandom_range(1, 8));
        endcase
        if (phase == 0) begin
            d = 8'h00; q = 8'hFF; qen = 8'h01; een = 8'h01; cols = 8'd1;
        end else if (phase == 1) begin
            d = 8'hFF; q = 8'h00; qen = 8'h01; een = 8'h01; cols = 8'd64;
        end
        write_reg(CFG_DELIMITER, d);
        write_reg(CFG_QUOTE, q);
        write_reg(CFG_QUOTE_EN, qen);
        write_reg(CFG_ESCAPE, e);
        write_reg(CFG_ESCAPE_EN, een);
        write_reg(CFG_COLUMNS, cols);
    endtask

    initial begin
        int target;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: blank line, byte extremes, extra field dropped
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'd44, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b1);
        drain();

        // escape shares the quote byte: escape wins
        write_reg(CFG_COLUMNS, 8'd3);
        write_reg(CFG_ESCAPE, 8'd34);
        write_reg(CFG_ESCAPE_EN, 8'd1);
        write_reg(CFG_SPARE_6, 8'hFF);
        write_reg(CFG_SPARE_7, 8'hFF);
        send_item(8'd34, 1'b0);
        send_item(8'd34, 1'b0);
        send_item(8'd44, 1'b0);
        send_item(8'd34, 1'b0);
        send_item(8'd44, 1'b0);
        send_item(8'h00, 1'b1);
        drain();

        // zero columns acts as one; escape, quote and delimiter all the same byte
        write_reg(CFG_COLUMNS, 8'd0);
        write_reg(CFG_ESCAPE, 8'd44);
        write_reg(CFG_QUOTE, 8'd44);
        send_item(8'd44, 1'b0);
        send_item(8'd44, 1'b0);
        send_item(8'h00, 1'b1);
        drain();

        // quote beats delimiter; oversized column count saturates, full padding
        write_reg(CFG_ESCAPE_EN, 8'd0);
        write_reg(CFG_COLUMNS, 8'd127);
        send_item(8'd44, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'd44, 1'b0);
        send_item(8'h00, 1'b1);
        drain();

        // quoting off, escape left pending at end of line, column change mid-line
        write_reg(CFG_ESCAPE_EN, 8'd1);
        write_reg(CFG_ESCAPE, 8'd92);
        write_reg(CFG_QUOTE_EN, 8'd0);
        write_reg(CFG_QUOTE, 8'd34);
        write_reg(CFG_DELIMITER, 8'd44);
        write_reg(CFG_COLUMNS, 8'd2);
        send_item(8'd34, 1'b0);
        send_item(8'd44, 1'b0);
        send_item(8'd92, 1'b0);
        drain();
        write_reg(CFG_COLUMNS, 8'd5);
        send_item(8'h00, 1'b1);
        send_item(8'h7A, 1'b0);
        send_item(8'hFF, 1'b1);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_settings(phase);
            no_stall = (phase == 4);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(99) < 12)
                    send_item(8'($urandom), $urandom_range(7) == 0);
                else
                    send_line();
            end
            drain();
            no_stall = 1'b0;
        end

        if (trk.errors == 0 && trk.waiting() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/csvfs_pkg.sv
rtl/csvfs_front.sv
rtl/csvfs_queue.sv
rtl/csvfs_back.sv
rtl/csv_field_splitter.sv
dv/tb_csv_field_splitter.sv
